FILE: rtl/open_addressing_hash_table_defines.svh
// Assertion macros shared by the hash table RTL.
// Used by oaht_front and oaht_back; expects clk and rst in scope.
`ifndef OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH
`define OPEN_ADDRESSING_HASH_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OAHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define OAHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/oaht_pkg.sv
// Types and constants for the open-addressed hash table.
// No dependencies.
`default_nettype none
package oaht_pkg;

  localparam int KEY_W = 31;
  localparam int CMD_W = 2;
  localparam int CNT_W = 11;
  localparam int CFG_W = 11;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_QUAD   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_OCCUPIED = 2'd1;
  localparam logic [1:0] ST_DELETED  = 2'd2;

  localparam logic REG_PROBE_MODE = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  // reciprocal of ten: q = (x * RECIP10) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic             op_ok;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
  } req_t;

endpackage
`default_nettype wire

FILE: rtl/oaht_front.sv
// Front end: accepts requests, classifies them and queues them (two entries).
// Depends on oaht_pkg.
`default_nettype none
`include "open_addressing_hash_table_defines.svh"
module oaht_front
  import oaht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [CMD_W-1:0] command,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [1:0]       probe_mode,
  input  wire logic             clearing,
  output req_t                  q,
  output logic                  q_valid,
  input  wire logic             q_pop
);

  req_t       entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  req_t       incoming;

  assign busy    = clearing || (cnt == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt != 2'd0);
  assign q       = entries[rp];

  always_comb begin
    incoming.op_ok   = (probe_mode == MODE_LINEAR || probe_mode == MODE_QUAD ||
                        probe_mode == MODE_DOUBLE) &&
                       (command == CMD_INSERT || command == CMD_REMOVE ||
                        command == CMD_SEARCH);
    incoming.command = command;
    incoming.key     = key;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      if (push && !q_pop) begin
        cnt <= cnt + 2'd1;
      end else if (!push && q_pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  `OAHT_ASSERT_NXT(a_push_fills, push, cnt != 2'd0, "queue empty after push")
  `OAHT_ASSERT_IMP(a_pop_valid, q_pop, cnt != 2'd0, "pop from empty queue")
  `OAHT_ASSERT_IMP(a_full_busy, cnt == 2'd2, busy, "full queue not busy")

endmodule
`default_nettype wire

FILE: rtl/oaht_back.sv
// Back end: probe sequencer with serial remainder unit and slot memories.
// Depends on oaht_pkg.
`default_nettype none
`include "open_addressing_hash_table_defines.svh"
module oaht_back
  import oaht_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [$clog2(DEPTH+1)-1:0]     size,
  input  wire logic [1:0]                     mode,
  input  wire logic                           clr_start,
  input  req_t                                q,
  input  wire logic                           q_valid,
  output logic                                q_pop,
  output logic                                clearing,
  output logic                                done,
  output logic                                ok,
  output logic [CNT_W-1:0]                    probe_count
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH+1);
  localparam int RW = SW + 4;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_RMUL = 3'd2;
  localparam logic [2:0] S_RDIG = 3'd3;
  localparam logic [2:0] S_INIT = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;

  logic [1:0]       status_mem [DEPTH];
  logic [KEY_W-1:0] key_mem    [DEPTH];
  logic [1:0]       status_q;
  logic [KEY_W-1:0] key_q;

  logic [2:0]       state;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key_r;
  logic [AW-1:0]    h, off, dq, rev, slot, k, ff_slot;
  logic             ff_valid;
  logic [SW:0]      rem;
  logic [KEY_W-1:0] dsh;
  logic [4:0]       mcnt;
  logic             mod_rev;
  logic [KEY_W-1:0] kk;
  logic [62:0]      prod;
  logic             clr_active;
  logic [AW-1:0]    clr_idx;

  logic [SW:0]      rem_sh, rem_n;
  logic [AW:0]      size_a, sum, off_s, dq_s, k_inc, limit_a, step;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] qt;
  logic [3:0]       digit;
  logic [RW-1:0]    dv;
  logic             st_empty, st_hit, last, ffv_now;
  logic [AW-1:0]    ffs_now;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [1:0]       wr_status;
  logic             key_we;

  assign clearing = clr_active;
  assign q_pop    = (state == S_IDLE) && q_valid && !done && !clr_active;
  assign size_a   = (AW+1)'(size);
  assign limit_a  = size_a - (AW+1)'(2);

  always_comb begin
    rem_sh = {rem[SW-1:0], dsh[KEY_W-1]};
    rem_n  = (rem_sh >= {1'b0, size}) ? rem_sh - {1'b0, size} : rem_sh;
  end

  always_comb begin
    qt    = KEY_W'(prod[62:35]);
    digit = 4'(kk - (qt << 3) - (qt << 1));
    dv    = (RW'(rev) << 3) + (RW'(rev) << 1) + RW'(digit);
  end

  always_comb begin
    sum     = {1'b0, h} + {1'b0, off};
    rd_addr = (sum >= size_a) ? AW'(sum - size_a) : AW'(sum);
  end

  always_comb begin
    unique case (mode)
      MODE_QUAD:   step = {1'b0, dq};
      MODE_DOUBLE: step = {1'b0, rev};
      default:     step = (AW+1)'(1);
    endcase
    off_s    = {1'b0, off} + step;
    dq_s     = {1'b0, dq} + (AW+1)'(2);
    k_inc    = {1'b0, k} + (AW+1)'(1);
    st_empty = (status_q == ST_EMPTY);
    st_hit   = (status_q == ST_OCCUPIED) && (key_q == key_r);
    last     = (k_inc == limit_a);
    ffv_now  = ff_valid || (status_q != ST_OCCUPIED);
    ffs_now  = ff_valid ? ff_slot : slot;
  end

  // memory write port: clearing sweep or the end of a walk
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = slot;
    wr_status = ST_EMPTY;
    key_we    = 1'b0;
    if (clr_active) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
    end else if (state == S_CHK && (st_empty || st_hit || last)) begin
      if (cmd == CMD_REMOVE && st_hit) begin
        wr_en     = 1'b1;
        wr_status = ST_DELETED;
      end else if (cmd == CMD_INSERT && !st_hit && ffv_now) begin
        wr_en     = 1'b1;
        wr_addr   = ffs_now;
        wr_status = ST_OCCUPIED;
        key_we    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      status_mem[wr_addr] <= wr_status;
    end
    if (key_we) begin
      key_mem[wr_addr] <= key_r;
    end
    status_q <= status_mem[rd_addr];
    key_q    <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_start) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(DEPTH-1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= 63'(kk) * 63'(RECIP10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      ok          <= 1'b0;
      probe_count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (!q.op_ok) begin
              done        <= 1'b1;
              ok          <= 1'b0;
              probe_count <= '0;
            end else begin
              cmd     <= q.command;
              key_r   <= q.key;
              dsh     <= q.key;
              rem     <= '0;
              mcnt    <= 5'(KEY_W);
              mod_rev <= 1'b0;
              state   <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem  <= rem_n;
          dsh  <= dsh << 1;
          mcnt <= mcnt - 5'd1;
          if (mcnt == 5'd1) begin
            rem <= '0;
            if (mod_rev) begin
              rev   <= AW'(rem_n);
              state <= (kk == '0) ? S_INIT : S_RMUL;
            end else begin
              h   <= AW'(rem_n);
              rev <= '0;
              kk  <= key_r;
              if (mode == MODE_DOUBLE && key_r != '0) begin
                state <= S_RMUL;
              end else begin
                state <= S_INIT;
              end
            end
          end
        end
        S_RMUL: begin
          state <= S_RDIG;
        end
        S_RDIG: begin
          dsh     <= {dv, {(KEY_W-RW){1'b0}}};
          mcnt    <= 5'(RW);
          mod_rev <= 1'b1;
          kk      <= qt;
          state   <= S_MOD;
        end
        S_INIT: begin
          k        <= '0;
          off      <= '0;
          dq       <= AW'(1);
          ff_valid <= 1'b0;
          state    <= S_RD;
        end
        S_RD: begin
          slot  <= rd_addr;
          state <= S_CHK;
        end
        S_CHK: begin
          if (!ff_valid && status_q != ST_OCCUPIED) begin
            ff_valid <= 1'b1;
            ff_slot  <= slot;
          end
          if (st_empty || st_hit || last) begin
            state <= S_IDLE;
            done  <= 1'b1;
            unique case (cmd)
              CMD_SEARCH: begin
                ok          <= st_hit;
                probe_count <= (st_empty || st_hit) ? CNT_W'(k_inc)
                                                    : CNT_W'(size_a - (AW+1)'(1));
              end
              CMD_REMOVE: begin
                ok          <= st_hit;
                probe_count <= '0;
              end
              default: begin
                ok          <= !st_hit && ffv_now;
                probe_count <= '0;
              end
            endcase
          end else begin
            k     <= AW'(k_inc);
            off   <= (off_s >= size_a) ? AW'(off_s - size_a) : AW'(off_s);
            dq    <= (dq_s >= size_a) ? AW'(dq_s - size_a) : AW'(dq_s);
            state <= S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OAHT_ASSERT_NXT(a_done_single, done, !done, "back-to-back result strobes")
  `OAHT_ASSERT_IMP(a_chk_after_rd, state == S_CHK, $past(state) == S_RD,
                   "check without a slot read")
  `OAHT_ASSERT_IMP(a_no_pop_clear, clr_active, !q_pop, "request taken while clearing")

endmodule
`default_nettype wire

FILE: rtl/open_addressing_hash_table.sv
// done rises once the request is popped, the key remainder is formed, the walk is set up
//   and each probe slot is read and checked; an undefined request answers in the cycle after
//   its pop. Double hashing adds a multiply, a digit step and a remainder over RW bits per
//   decimal digit of the key (RW = size bits + 4). Transactions run one at a time; a 2-entry
//   queue takes up to two more. Reset clears config (linear, size DEPTH) and sweeps DEPTH slots
//   to empty, as does each table_size write; busy is high during the sweep. done lasts one cycle.
`default_nettype none
module open_addressing_hash_table
  import oaht_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [CMD_W-1:0] command,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output logic                  done,
  output logic                  ok,
  output logic [CNT_W-1:0]      probe_count
);

  localparam int SW = $clog2(DEPTH+1);

  logic [1:0]    probe_mode;
  logic [SW-1:0] table_size;
  logic          clr_start;
  logic          clearing;
  logic          q_valid;
  logic          q_pop;
  req_t          q;

  // Configuration: store the probe mode, or clamp the size into [3, DEPTH] and kick off a clearing sweep.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode <= MODE_LINEAR;
      table_size <= SW'(DEPTH);
      clr_start  <= 1'b0;
    end else begin
      clr_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROBE_MODE: begin
            probe_mode <= cfg_data[1:0];
          end
          default: begin
            clr_start <= 1'b1;
            if (cfg_data < CFG_W'(3)) begin
              table_size <= SW'(3);
            end else if (32'(cfg_data) > 32'(DEPTH)) begin
              table_size <= SW'(DEPTH);
            end else begin
              table_size <= SW'(cfg_data);
            end
          end
        endcase
      end
    end
  end

  // Front: accept and classify each transaction into the queue.
  oaht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .key        (key),
    .probe_mode (probe_mode),
    .clearing   (clearing),
    .q          (q),
    .q_valid    (q_valid),
    .q_pop      (q_pop)
  );

  // Back: hash, walk the probe sequence, update slots, report.
  oaht_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .size        (table_size),
    .mode        (probe_mode),
    .clr_start   (clr_start),
    .q           (q),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .done        (done),
    .ok          (ok),
    .probe_count (probe_count)
  );

endmodule
`default_nettype wire
